>>> hdl/dsi_pkg.sv
// ----------------------------------------------------------------------------
// dsi_pkg: shared types and constants of the depth sample interpolator
// Field widths, register defaults, register indexes and the divide-by-constant
// reciprocals used by the averaging stages.
// ----------------------------------------------------------------------------
`default_nettype none

package dsi_pkg;

  localparam int COORD_W    = 21;
  localparam int SAMPLE_W   = 16;
  localparam int DIM_W      = 13;
  localparam int SUM_W      = SAMPLE_W + 2;
  localparam int THRES_W    = 10;

  localparam int FRACTION_BITS_DEF        = 8;
  localparam int WEIGHT_FRACTION_BITS_DEF = 16;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd512;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd424;

  // Exact floor(s / 3) for s below 2^19: (s * RECIP3) >> RECIP3_SH.
  localparam int RECIP3_SH = 20;
  localparam logic [18:0] RECIP3 = 19'd349526;
  // Exact floor(a / 100) for a below 2^16: (a * RECIP100) >> RECIP100_SH.
  localparam int RECIP100_SH = 23;
  localparam logic [16:0] RECIP100 = 17'd83887;

  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // Truncated integer square root, evaluated at elaboration only.
  function automatic logic [63:0] isqrt_const(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = v;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bitv != 0) begin
        if (rem >= res + bitv) begin
          rem = rem - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hdl/dsi_sample_if.sv
// ----------------------------------------------------------------------------
// dsi_sample_if: input channel of the depth sample interpolator
// Carries one sample position and its four neighboring depths per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface dsi_sample_if
  import dsi_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  coord_x;
  logic signed [COORD_W-1:0]  coord_y;
  logic [SAMPLE_W-1:0]        sample_top_left;
  logic [SAMPLE_W-1:0]        sample_top_right;
  logic [SAMPLE_W-1:0]        sample_bottom_left;
  logic [SAMPLE_W-1:0]        sample_bottom_right;

  modport source (
    output valid, coord_x, coord_y, sample_top_left, sample_top_right,
           sample_bottom_left, sample_bottom_right,
    input  ready
  );
  modport sink (
    input  valid, coord_x, coord_y, sample_top_left, sample_top_right,
           sample_bottom_left, sample_bottom_right,
    output ready
  );
endinterface

`default_nettype wire

>>> hdl/dsi_depth_if.sv
// ----------------------------------------------------------------------------
// dsi_depth_if: output channel of the depth sample interpolator
// Carries one interpolated depth per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface dsi_depth_if
  import dsi_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] depth_out;

  modport source (output valid, depth_out, input ready);
  modport sink   (input valid, depth_out, output ready);
endinterface

`default_nettype wire

>>> hdl/depth_sample_interpolator.sv
// ----------------------------------------------------------------------------
// depth_sample_interpolator: distance-weighted bilinear depth interpolation
// Rejects out-of-image, sparse or inconsistent neighborhoods and otherwise
// returns the rounded weighted mean of the consistent depth samples.
// ----------------------------------------------------------------------------
//   channel     dir  handshake     payload
//   sample_in   in   valid/ready   coord_x, coord_y, four 16-bit samples
//   depth_res   out  valid/ready   depth_out
//   cfg         in   cfg_we        cfg_index, cfg_data (no read-back)
//
// One beat is accepted per cycle unless depth_res stalls; the depth passes
// through the one-bit-per-stage square root and the 16-stage divider.
// Reset clears the valid bits and loads width 512 and height 424.
// A stall on depth_res freezes every stage at once; sample_in.ready is low
// only while the final stage holds a beat that is not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_sample_interpolator
  import dsi_pkg::*;
#(
  parameter int FRACTION_BITS        = FRACTION_BITS_DEF,
  parameter int WEIGHT_FRACTION_BITS = WEIGHT_FRACTION_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [DIM_W-1:0]  cfg_data,
  dsi_sample_if.sink             sample_in,
  dsi_depth_if.source            depth_res
);

  localparam int F     = FRACTION_BITS;
  localparam int R     = WEIGHT_FRACTION_BITS + 1;
  localparam int AX_W  = F + 1;
  localparam int SQ_W  = 2 * F + 2;
  localparam int RAD_W = 2 * R;
  localparam int XL_W  = COORD_W - 1 - F;
  localparam int XH_W  = XL_W + 1;
  localparam int BW    = (XH_W > DIM_W) ? XH_W : DIM_W;
  localparam int PR_W  = SAMPLE_W + R;
  localparam int NUM_W = PR_W + 2;
  localparam int DEN_W = R + 2;
  localparam int DVD_W = NUM_W + 1;
  localparam int DVS_W = DEN_W + 1;
  localparam int L     = R - 2;
  localparam int LAT   = R + 21;
  localparam logic [AX_W-1:0] ONE   = AX_W'(1) << F;
  localparam logic [R-1:0]    ROOT2 =
    R'(isqrt_const(64'd2 << (2 * WEIGHT_FRACTION_BITS)));

  typedef struct packed {
    logic [3:0][SAMPLE_W-1:0] smp;
    logic [3:0]               ok;
    logic                     rej;
  } side_t;

  // Configuration registers.
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
      endcase
    end
  end

  // Global advance: every stage moves unless the last one is stuck.
  logic           adv;
  logic [LAT-1:0] vld;

  assign adv             = !vld[LAT-1] || depth_res.ready;
  assign sample_in.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], sample_in.valid};
    end
  end

  // Stage 1: bounds, nonzero count, sum and squared axis distances.
  logic [3:0][SAMPLE_W-1:0] in_smp;
  logic [F-1:0]             fx, fy;
  logic [XH_W-1:0]          xh, yh;
  logic [AX_W-1:0]          ax_lo, ax_hi, ay_lo, ay_hi;
  logic                     oob;
  logic [2:0]               nz_cnt;
  logic [SUM_W-1:0]         smp_sum;

  logic [3:0][SAMPLE_W-1:0] s1_smp;
  logic                     s1_rej;
  logic [2:0]               s1_cnt;
  logic [SUM_W-1:0]         s1_sum;
  logic [SQ_W-1:0]          s1_sqx_lo, s1_sqx_hi, s1_sqy_lo, s1_sqy_hi;

  always_comb begin
    in_smp = {sample_in.sample_bottom_right, sample_in.sample_bottom_left,
              sample_in.sample_top_right, sample_in.sample_top_left};
    fx     = sample_in.coord_x[F-1:0];
    fy     = sample_in.coord_y[F-1:0];
    xh     = XH_W'(sample_in.coord_x[COORD_W-2:F]) + XH_W'(fx != '0);
    yh     = XH_W'(sample_in.coord_y[COORD_W-2:F]) + XH_W'(fy != '0);
    oob    = sample_in.coord_x[COORD_W-1] || sample_in.coord_y[COORD_W-1] ||
             (BW'(xh) >= BW'(image_width)) || (BW'(yh) >= BW'(image_height));
    ax_lo  = AX_W'(fx);
    ay_lo  = AX_W'(fy);
    ax_hi  = ONE - ax_lo;
    ay_hi  = ONE - ay_lo;
    nz_cnt  = '0;
    smp_sum = '0;
    for (int k = 0; k < 4; k++) begin
      nz_cnt  = nz_cnt + 3'(in_smp[k] != '0);
      smp_sum = smp_sum + SUM_W'(in_smp[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_smp    <= in_smp;
      s1_rej    <= oob;
      s1_cnt    <= nz_cnt;
      s1_sum    <= smp_sum;
      s1_sqx_lo <= SQ_W'(ax_lo) * SQ_W'(ax_lo);
      s1_sqx_hi <= SQ_W'(ax_hi) * SQ_W'(ax_hi);
      s1_sqy_lo <= SQ_W'(ay_lo) * SQ_W'(ay_lo);
      s1_sqy_hi <= SQ_W'(ay_hi) * SQ_W'(ay_hi);
    end
  end

  // Stage 2: average of the nonzero samples and rescaled squared distances.
  logic [3:0][SQ_W-1:0]  d2;
  logic [3:0][RAD_W-1:0] rad;
  logic [SUM_W+18:0]     div3_prod;
  logic [SAMPLE_W-1:0]   avg;

  logic [3:0][SAMPLE_W-1:0] s2_smp;
  logic                     s2_rej;
  logic [SAMPLE_W-1:0]      s2_avg;
  logic [3:0][RAD_W-1:0]    s2_rad;

  always_comb begin
    d2[0]     = s1_sqx_lo + s1_sqy_lo;
    d2[1]     = s1_sqx_hi + s1_sqy_lo;
    d2[2]     = s1_sqx_lo + s1_sqy_hi;
    d2[3]     = s1_sqx_hi + s1_sqy_hi;
    div3_prod = (SUM_W + 19)'(s1_sum) * (SUM_W + 19)'(RECIP3);
    if (s1_cnt == 3'd4) begin
      avg = s1_sum[SAMPLE_W+1:2];
    end else begin
      avg = div3_prod[RECIP3_SH +: SAMPLE_W];
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_rescale
    if (WEIGHT_FRACTION_BITS >= F) begin : g_up
      assign rad[k] = RAD_W'(d2[k]) << (2 * (WEIGHT_FRACTION_BITS - F));
    end else begin : g_down
      assign rad[k] = RAD_W'(d2[k] >> (2 * (F - WEIGHT_FRACTION_BITS)));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_smp <= s1_smp;
      s2_rej <= s1_rej || (s1_cnt < 3'd3);
      s2_avg <= avg;
      s2_rad <= rad;
    end
  end

  // Square roots of the four distances run beside the consistency stages.
  logic [3:0][R-1:0] root;

  for (genvar k = 0; k < 4; k++) begin : g_sqrt
    dsi_isqrt #(.RW(R)) u_isqrt (
      .clk      (clk),
      .adv      (adv),
      .radicand (s2_rad[k]),
      .root     (root[k])
    );
  end

  // Stage 3: consistency threshold floor(avg / 100).
  logic [SAMPLE_W+16:0] div100_prod;

  logic [3:0][SAMPLE_W-1:0] s3_smp;
  logic                     s3_rej;
  logic [SAMPLE_W-1:0]      s3_avg;
  logic [THRES_W-1:0]       s3_thr;

  assign div100_prod = (SAMPLE_W + 17)'(s2_avg) * (SAMPLE_W + 17)'(RECIP100);

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_smp <= s2_smp;
      s3_rej <= s2_rej;
      s3_avg <= s2_avg;
      s3_thr <= div100_prod[RECIP100_SH +: THRES_W];
    end
  end

  // Stage 4: per-sample consistency and the three-sample rule.
  logic [3:0]          ok;
  logic [2:0]          ok_cnt;
  logic [SAMPLE_W-1:0] diff;
  side_t               s4_side;

  always_comb begin
    ok     = '0;
    ok_cnt = '0;
    diff   = '0;
    for (int k = 0; k < 4; k++) begin
      diff   = (s3_smp[k] > s3_avg) ? s3_smp[k] - s3_avg : s3_avg - s3_smp[k];
      ok[k]  = diff < SAMPLE_W'(s3_thr);
      ok_cnt = ok_cnt + 3'(ok[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_side.smp <= s3_smp;
      s4_side.ok  <= ok;
      s4_side.rej <= s3_rej || (ok_cnt < 3'd3);
    end
  end

  // Delay line that lines the side data up with the square roots.
  side_t side_dl [L];

  always_ff @(posedge clk) begin
    if (adv) begin
      side_dl[0] <= s4_side;
      for (int j = 1; j < L; j++) begin
        side_dl[j] <= side_dl[j-1];
      end
    end
  end

  // Weight stage: sqrt(2) minus distance, zero for inconsistent samples.
  logic [3:0][R-1:0]        sw_w;
  logic [3:0][SAMPLE_W-1:0] sw_smp;
  logic                     sw_rej;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        sw_w[k] <= (side_dl[L-1].ok[k] && root[k] <= ROOT2) ? ROOT2 - root[k] : '0;
      end
      sw_smp <= side_dl[L-1].smp;
      sw_rej <= side_dl[L-1].rej;
    end
  end

  // Product stage: sample times weight, and the weight sum.
  logic [3:0][PR_W-1:0] sm_prod;
  logic [DEN_W-1:0]     sm_den;
  logic                 sm_rej;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        sm_prod[k] <= PR_W'(sw_smp[k]) * PR_W'(sw_w[k]);
      end
      sm_den <= DEN_W'(sw_w[0]) + DEN_W'(sw_w[1]) + DEN_W'(sw_w[2]) + DEN_W'(sw_w[3]);
      sm_rej <= sw_rej;
    end
  end

  // Sum stage: rounded-division operands (2*num + den) and 2*den.
  logic [NUM_W-1:0] num;
  logic [DVD_W-1:0] sn_dvd;
  logic [DVS_W-1:0] sn_dvs;
  logic             sn_zero;

  assign num = NUM_W'(sm_prod[0]) + NUM_W'(sm_prod[1]) +
               NUM_W'(sm_prod[2]) + NUM_W'(sm_prod[3]);

  always_ff @(posedge clk) begin
    if (adv) begin
      sn_dvd  <= {num, 1'b0} + DVD_W'(sm_den);
      sn_dvs  <= {sm_den, 1'b0};
      sn_zero <= sm_rej || (sm_den == '0);
    end
  end

  // Division and the matching delay of the reject flag.
  logic [SAMPLE_W-1:0] quot;
  logic [SAMPLE_W-1:0] zero_dl;

  dsi_divider #(.DVD_W(DVD_W), .DVS_W(DVS_W), .QW(SAMPLE_W)) u_divider (
    .clk      (clk),
    .adv      (adv),
    .dividend (sn_dvd),
    .divisor  (sn_dvs),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      zero_dl <= {zero_dl[SAMPLE_W-2:0], sn_zero};
    end
  end

  assign depth_res.valid     = vld[LAT-1];
  assign depth_res.depth_out = zero_dl[SAMPLE_W-1] ? '0 : quot;

  // Checks on the pipeline.
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    sample_in.valid && sample_in.ready |=> vld[0])
    else $error("accepted beat did not enter the first stage");

  a_root: assert property (@(posedge clk) disable iff (rst)
    vld[R+1] |-> (root[0] <= ROOT2 && root[1] <= ROOT2 &&
                  root[2] <= ROOT2 && root[3] <= ROOT2))
    else $error("distance root exceeds sqrt(2)");

  a_kept: assert property (@(posedge clk) disable iff (rst)
    vld[3] && !s4_side.rej |-> $countones(s4_side.ok) >= 3)
    else $error("kept beat has fewer than three consistent samples");

endmodule

`default_nettype wire

>>> hdl/dsi_isqrt.sv
// ----------------------------------------------------------------------------
// dsi_isqrt: pipelined truncated integer square root
// One root bit per stage, RW stages; all stages move together on adv.
// ----------------------------------------------------------------------------
`default_nettype none

module dsi_isqrt
  import dsi_pkg::*;
#(
  parameter int RW = WEIGHT_FRACTION_BITS_DEF + 1
) (
  input  wire logic            clk,
  input  wire logic            adv,
  input  wire logic [2*RW-1:0] radicand,
  output logic      [RW-1:0]   root
);

  logic [2*RW-1:0] rad_s [RW+1];
  logic [RW+1:0]   rem_s [RW+1];
  logic [RW-1:0]   res_s [RW+1];

  assign rad_s[0] = radicand;
  assign rem_s[0] = '0;
  assign res_s[0] = '0;

  for (genvar i = 0; i < RW; i++) begin : g_stage
    localparam int B = RW - 1 - i;
    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;

    // Bring down the next two radicand bits and try a one in this root bit.
    always_comb begin
      rem_sh = {rem_s[i][RW-1:0], rad_s[i][2*B+1 -: 2]};
      trial  = {res_s[i], 2'b01};
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rad_s[i+1] <= rad_s[i];
        if (rem_sh >= trial) begin
          rem_s[i+1] <= rem_sh - trial;
          res_s[i+1] <= {res_s[i][RW-2:0], 1'b1};
        end else begin
          rem_s[i+1] <= rem_sh;
          res_s[i+1] <= {res_s[i][RW-2:0], 1'b0};
        end
      end
    end
  end

  assign root = res_s[RW];

endmodule

`default_nettype wire

>>> hdl/dsi_divider.sv
// ----------------------------------------------------------------------------
// dsi_divider: pipelined restoring divider
// One quotient bit per stage, QW stages; the quotient must fit in QW bits.
// ----------------------------------------------------------------------------
`default_nettype none

module dsi_divider
  import dsi_pkg::*;
#(
  parameter int DVD_W = 36,
  parameter int DVS_W = 20,
  parameter int QW    = SAMPLE_W
) (
  input  wire logic             clk,
  input  wire logic             adv,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic      [QW-1:0]    quotient
);

  logic [DVD_W-1:0] rem_s [QW+1];
  logic [DVS_W-1:0] dvs_s [QW+1];
  logic [QW-1:0]    quo_s [QW+1];

  assign rem_s[0] = dividend;
  assign dvs_s[0] = divisor;
  assign quo_s[0] = '0;

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int K = QW - 1 - j;
    logic [DVD_W-1:0] shifted;

    // Compare against the divisor aligned to this quotient bit.
    always_comb begin
      shifted = DVD_W'(dvs_s[j]) << K;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dvs_s[j+1] <= dvs_s[j];
        if (rem_s[j] >= shifted) begin
          rem_s[j+1] <= rem_s[j] - shifted;
          quo_s[j+1] <= quo_s[j] | (QW'(1) << K);
        end else begin
          rem_s[j+1] <= rem_s[j];
          quo_s[j+1] <= quo_s[j];
        end
      end
    end
  end

  assign quotient = quo_s[QW];

endmodule

`default_nettype wire
